// ----- rtl/cna_pkg.sv -----
// ----------------------------------------------------------------------------
// cna_pkg - shared types and constants for the complex number ALU
// Operation codes and the fixed width of the result fields.
// ----------------------------------------------------------------------------
package cna_pkg;

  localparam int unsigned OUT_WIDTH = 49;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } cna_op_e;

endpackage

// ----- rtl/cna_if.sv -----
// ----------------------------------------------------------------------------
// cna_if - request and response channels of the complex number ALU
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cna_req_if #(
  parameter int unsigned OPERAND_WIDTH = 16
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic signed [OPERAND_WIDTH-1:0] a_real;
  logic signed [OPERAND_WIDTH-1:0] a_imag;
  logic signed [OPERAND_WIDTH-1:0] b_real;
  logic signed [OPERAND_WIDTH-1:0] b_imag;

  modport source (output valid, req_type, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, req_type, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cna_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [cna_pkg::OUT_WIDTH-1:0] real_out;
  logic signed [cna_pkg::OUT_WIDTH-1:0] imag_out;
  logic                                div_by_zero;

  modport source (output valid, real_out, imag_out, div_by_zero, input ready);
  modport sink   (input valid, real_out, imag_out, div_by_zero, output ready);
endinterface

// ----- rtl/cna_div_pipe.sv -----
// ----------------------------------------------------------------------------
// cna_div_pipe - pipelined restoring divider, two lanes sharing a divisor
// One quotient bit per stage; a sideband word travels alongside.
// ----------------------------------------------------------------------------
module cna_div_pipe #(
  parameter int unsigned PW   = 32,  // dividend magnitude / divisor width
  parameter int unsigned HW   = 16,  // dividend bits below the first remainder
  parameter int unsigned DS   = 32,  // quotient bits = stages
  parameter int unsigned SB_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [SB_W-1:0]         sb_i,
  input  logic [1:0][PW-1:0]      num_i,
  input  logic [PW-1:0]           den_i,
  output logic                    valid_o,
  output logic [SB_W-1:0]         sb_o,
  output logic [1:0][DS-1:0]      quo_o
);

  localparam int unsigned FB = DS - HW;

  logic                 vld   [DS+1];
  logic [SB_W-1:0]      sb    [DS+1];
  logic [PW-1:0]        den   [DS+1];
  logic [1:0][PW-1:0]   rem   [DS+1];
  logic [1:0][DS-1:0]   bits  [DS+1];
  logic [1:0][DS-1:0]   quo   [DS+1];

  // first remainder is the part above the quotient range, always below den
  assign vld[0] = valid_i;
  assign sb[0]  = sb_i;
  assign den[0] = den_i;
  for (genvar l = 0; l < 2; l++) begin : g_init
    assign rem[0][l]  = PW'(num_i[l] >> HW);
    assign bits[0][l] = {num_i[l][HW-1:0], {FB{1'b0}}};
    assign quo[0][l]  = '0;
  end

  for (genvar s = 0; s < DS; s++) begin : g_stage
    logic [1:0][PW-1:0] rem_d;
    logic [1:0]         qbit;

    always_comb begin
      logic [PW:0] trial;
      logic [PW:0] diff;
      for (int l = 0; l < 2; l++) begin
        trial = {rem[s][l], bits[s][l][DS-1]};
        diff  = trial - {1'b0, den[s]};
        qbit[l] = ~diff[PW];
        rem_d[l] = diff[PW] ? trial[PW-1:0] : diff[PW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[s+1] <= 1'b0;
      end else if (en_i) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sb[s+1]  <= sb[s];
        den[s+1] <= den[s];
        rem[s+1] <= rem_d;
        for (int l = 0; l < 2; l++) begin
          bits[s+1][l] <= bits[s][l] << 1;
          quo[s+1][l]  <= {quo[s][l][DS-2:0], qbit[l]};
        end
      end
    end
  end

  assign valid_o = vld[DS];
  assign sb_o    = sb[DS];
  assign quo_o   = quo[DS];

endmodule

// ----- rtl/cna_front.sv -----
// ----------------------------------------------------------------------------
// cna_front - operand register, product and sum stages
// Three stages: capture, six products with add/sub, final sums and signs.
// ----------------------------------------------------------------------------
module cna_front #(
  parameter int unsigned W = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [1:0]               op_i,
  input  logic signed [W-1:0]      ar_i,
  input  logic signed [W-1:0]      ai_i,
  input  logic signed [W-1:0]      br_i,
  input  logic signed [W-1:0]      bi_i,
  output logic                     valid_o,
  output logic [1:0]               op_o,
  output logic                     flag_o,
  output logic signed [2*W:0]      dir_re_o,
  output logic signed [2*W:0]      dir_im_o,
  output logic [1:0]               neg_o,
  output logic [1:0][2*W-1:0]      mag_o,
  output logic [2*W-1:0]           den_o
);
  import cna_pkg::*;

  localparam int unsigned PW = 2 * W;

  logic                 v1_q, v2_q, v3_q;
  logic [1:0]           op1_q, op2_q, op3_q;
  logic signed [W-1:0]  ar1_q, ai1_q, br1_q, bi1_q;
  logic                 zero2_q;
  logic signed [W:0]    sre2_q, sim2_q;
  logic signed [PW-1:0] rr2_q, ii2_q, ri2_q, ir2_q, bbr2_q, bbi2_q;
  logic                 flag3_q;
  logic signed [PW:0]   dre3_q, dim3_q;
  logic [1:0]           neg3_q;
  logic [1:0][PW-1:0]   mag3_q;
  logic [PW-1:0]        den3_q;

  logic signed [PW:0]   num_re, num_im;

  assign num_re = (PW+1)'(rr2_q) + (PW+1)'(ii2_q);
  assign num_im = (PW+1)'(ir2_q) - (PW+1)'(ri2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // capture
      op1_q <= op_i;
      ar1_q <= ar_i;
      ai1_q <= ai_i;
      br1_q <= br_i;
      bi1_q <= bi_i;
      // products
      op2_q   <= op1_q;
      zero2_q <= (br1_q == '0) && (bi1_q == '0);
      sre2_q  <= (op1_q == OP_SUB) ? (W+1)'(ar1_q) - (W+1)'(br1_q)
                                   : (W+1)'(ar1_q) + (W+1)'(br1_q);
      sim2_q  <= (op1_q == OP_SUB) ? (W+1)'(ai1_q) - (W+1)'(bi1_q)
                                   : (W+1)'(ai1_q) + (W+1)'(bi1_q);
      rr2_q   <= ar1_q * br1_q;
      ii2_q   <= ai1_q * bi1_q;
      ri2_q   <= ar1_q * bi1_q;
      ir2_q   <= ai1_q * br1_q;
      bbr2_q  <= br1_q * br1_q;
      bbi2_q  <= bi1_q * bi1_q;
      // sums
      op3_q   <= op2_q;
      flag3_q <= (op2_q == OP_DIV) && zero2_q;
      if (op2_q == OP_MUL) begin
        dre3_q <= (PW+1)'(rr2_q) - (PW+1)'(ii2_q);
        dim3_q <= (PW+1)'(ri2_q) + (PW+1)'(ir2_q);
      end else begin
        dre3_q <= (PW+1)'(sre2_q);
        dim3_q <= (PW+1)'(sim2_q);
      end
      neg3_q    <= {num_im[PW], num_re[PW]};
      mag3_q[0] <= num_re[PW] ? PW'(-num_re) : num_re[PW-1:0];
      mag3_q[1] <= num_im[PW] ? PW'(-num_im) : num_im[PW-1:0];
      den3_q    <= PW'(bbr2_q) + PW'(bbi2_q);
    end
  end

  assign valid_o  = v3_q;
  assign op_o     = op3_q;
  assign flag_o   = flag3_q;
  assign dir_re_o = dre3_q;
  assign dir_im_o = dim3_q;
  assign neg_o    = neg3_q;
  assign mag_o    = mag3_q;
  assign den_o    = den3_q;

endmodule

// ----- rtl/complex_number_alu.sv -----
// ----------------------------------------------------------------------------
// complex_number_alu - add, subtract, multiply and divide of complex words
// Fully pipelined; one request word in and one response word out per cycle while the receiver does not stall.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries req_type (0 add, 1 subtract, 2 multiply, 3 divide) and the
//   two signed operands a and b. rsp_o returns real_out, imag_out and
//   div_by_zero. Add, subtract and multiply give exact integers; divide
//   gives a*conj(b)/|b|^2 with FRACTION_BITS fraction bits, truncated toward
//   zero. A divide by b = 0 returns zero parts with div_by_zero set.
//   Every operation takes the same path: three front stages, one
//   restoring-divider stage per quotient bit, and the output register. A new
//   word can enter every cycle while the receiver does not stall, so
//   throughput is one word per cycle.
//   The whole pipeline advances when the output register is empty or being
//   taken; while the receiver stalls, every stage holds and req_i.ready is
//   low, so no word is dropped or repeated.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module complex_number_alu #(
  parameter int unsigned OPERAND_WIDTH = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  cna_req_if.sink  req_i,
  cna_rsp_if.source rsp_o
);
  import cna_pkg::*;

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned PW   = 2 * W;
  localparam int unsigned DS   = W + FRACTION_BITS;
  localparam int unsigned OW   = OUT_WIDTH;
  localparam int unsigned SB_W = 2 + 1 + 2 + 2 * (PW + 1);

  logic                 adv;
  logic                 f_valid;
  logic [1:0]           f_op;
  logic                 f_flag;
  logic signed [PW:0]   f_dre, f_dim;
  logic [1:0]           f_neg;
  logic [1:0][PW-1:0]   f_mag;
  logic [PW-1:0]        f_den;

  logic                 d_valid;
  logic [SB_W-1:0]      d_sb;
  logic [1:0][DS-1:0]   d_quo;

  logic [1:0]           o_op;
  logic                 o_flag;
  logic [1:0]           o_neg;
  logic signed [PW:0]   o_dre, o_dim;
  logic signed [OW-1:0] q_re, q_im;

  logic                 valid_q;
  logic signed [OW-1:0] re_q, re_d, im_q, im_d;
  logic                 flag_q;

  // advance everything when the output slot is free or being drained
  assign adv         = !valid_q || rsp_o.ready;
  assign req_i.ready = adv;

  cna_front #(.W(W)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (req_i.valid),
    .op_i     (req_i.req_type),
    .ar_i     (req_i.a_real),
    .ai_i     (req_i.a_imag),
    .br_i     (req_i.b_real),
    .bi_i     (req_i.b_imag),
    .valid_o  (f_valid),
    .op_o     (f_op),
    .flag_o   (f_flag),
    .dir_re_o (f_dre),
    .dir_im_o (f_dim),
    .neg_o    (f_neg),
    .mag_o    (f_mag),
    .den_o    (f_den)
  );

  // add/sub/mul results ride the divider as sideband to keep one latency
  cna_div_pipe #(.PW(PW), .HW(W), .DS(DS), .SB_W(SB_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (f_valid),
    .sb_i    ({f_op, f_flag, f_neg, f_dre, f_dim}),
    .num_i   (f_mag),
    .den_i   (f_den),
    .valid_o (d_valid),
    .sb_o    (d_sb),
    .quo_o   (d_quo)
  );

  assign {o_op, o_flag, o_neg, o_dre, o_dim} = d_sb;

  // apply the quotient sign
  assign q_re = o_neg[0] ? -OW'(d_quo[0]) : OW'(d_quo[0]);
  assign q_im = o_neg[1] ? -OW'(d_quo[1]) : OW'(d_quo[1]);

  always_comb begin
    if (o_flag) begin
      re_d = '0;
      im_d = '0;
    end else if (o_op == OP_DIV) begin
      re_d = q_re;
      im_d = q_im;
    end else begin
      re_d = OW'(o_dre);
      im_d = OW'(o_dim);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      re_q   <= re_d;
      im_q   <= im_d;
      flag_q <= o_flag;
    end
  end

  assign rsp_o.valid       = valid_q;
  assign rsp_o.real_out    = re_q;
  assign rsp_o.imag_out    = im_q;
  assign rsp_o.div_by_zero = flag_q;

endmodule

// ----- tb/complex_number_alu_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// complex_number_alu_tb - self-checking bench for the complex number ALU
// Feeds request words through a randomly idling driver, takes response words
// under random receiver stalls, and checks each one against a predicted
// result computed in the bench from the operands.
// ----------------------------------------------------------------------------
module complex_number_alu_tb;
  import cna_pkg::*;

  localparam int unsigned OW = 16;
  localparam int unsigned FB = 16;
  localparam int unsigned NUM_RANDOM = 550;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = OW + FB + 20;

  typedef struct packed {
    cna_op_e       op;
    logic [OW-1:0] ar;
    logic [OW-1:0] ai;
    logic [OW-1:0] br;
    logic [OW-1:0] bi;
  } alu_req_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] re;
    logic [OUT_WIDTH-1:0] im;
    logic                 dz;
  } alu_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cna_req_if #(.OPERAND_WIDTH(OW)) req_if ();
  cna_rsp_if rsp_if ();

  complex_number_alu #(.OPERAND_WIDTH(OW), .FRACTION_BITS(FB)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  alu_req_t pending_words[$];
  alu_rsp_t expected_results[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit stimulus_done = 1'b0;

  // Clamp a wide signed value to the 49-bit output range.
  function automatic logic [OUT_WIDTH-1:0] clamp_out(input logic signed [127:0] v);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (OUT_WIDTH - 1)) - 1;
    lo = -(128'sd1 <<< (OUT_WIDTH - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OUT_WIDTH-1:0];
  endfunction

  // Scale n by 2^FB and divide by d, truncating toward zero.
  function automatic logic [OUT_WIDTH-1:0] fixed_quotient(input logic signed [127:0] n,
                                                          input logic signed [127:0] d);
    logic signed [127:0] mag, q;
    mag = (n < 0) ? -n : n;
    q = (mag <<< FB) / d;
    return clamp_out((n < 0) ? -q : q);
  endfunction

  function automatic alu_rsp_t predict_result(input alu_req_t w);
    logic signed [127:0] ar, ai, br, bi, den;
    alu_rsp_t r;
    ar = $signed(w.ar);
    ai = $signed(w.ai);
    br = $signed(w.br);
    bi = $signed(w.bi);
    r = '0;
    case (w.op)
      OP_ADD: begin
        r.re = clamp_out(ar + br);
        r.im = clamp_out(ai + bi);
      end
      OP_SUB: begin
        r.re = clamp_out(ar - br);
        r.im = clamp_out(ai - bi);
      end
      OP_MUL: begin
        r.re = clamp_out(ar * br - ai * bi);
        r.im = clamp_out(ar * bi + ai * br);
      end
      default: begin
        if (br == 0 && bi == 0) begin
          r.dz = 1'b1;
        end else begin
          den = br * br + bi * bi;
          r.re = fixed_quotient(ar * br + ai * bi, den);
          r.im = fixed_quotient(ai * br - ar * bi, den);
        end
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [OUT_WIDTH-1:0] got,
                                 input logic [OUT_WIDTH-1:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what,
             $signed(got), $signed(want));
  endtask

  // No gap half the time, otherwise mostly a short one and now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic [OW-1:0] pick_operand();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_word(input cna_op_e op, input logic [OW-1:0] ar, ai, br, bi);
    alu_req_t w;
    w.op = op; w.ar = ar; w.ai = ai; w.br = br; w.bi = bi;
    pending_words.push_back(w);
  endtask

  // Driver: hold the word until it is taken, then advance after a gap.
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.req_type <= OP_ADD;
      req_if.a_real <= '0;
      req_if.a_imag <= '0;
      req_if.b_real <= '0;
      req_if.b_imag <= '0;
    end else if (!(req_if.valid && !req_if.ready)) begin
      // Current word was taken or nothing is on the bus.
      if (req_if.valid) begin
        expected_results.push_back(predict_result(pending_words.pop_front()));
        send_gap = idle_len();
      end
      if (send_gap > 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        req_if.valid <= 1'b1;
        req_if.req_type <= pending_words[0].op;
        req_if.a_real <= pending_words[0].ar;
        req_if.a_imag <= pending_words[0].ai;
        req_if.b_real <= pending_words[0].br;
        req_if.b_imag <= pending_words[0].bi;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each taken response with the oldest prediction.
  int unsigned stall_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    alu_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("[%0t] response word with no prediction pending", $realtime);
        end else begin
          want = expected_results.pop_front();
          if (rsp_if.real_out !== want.re) report_mismatch("real_out", rsp_if.real_out, want.re);
          if (rsp_if.imag_out !== want.im) report_mismatch("imag_out", rsp_if.imag_out, want.im);
          if (rsp_if.div_by_zero !== want.dz)
            report_mismatch("div_by_zero", rsp_if.div_by_zero, want.dz);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        stall_left = idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d words queued, %0d predictions pending",
               pending_words.size(), expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cna_op_e op;
    // Directed words: extremes, every operation, divide by zero.
    queue_word(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    queue_word(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_word(OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
    queue_word(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    queue_word(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_word(OP_MUL, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
    queue_word(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    queue_word(OP_MUL, 16'h0003, 16'hfffe, 16'h0000, 16'h0001);
    queue_word(OP_DIV, 16'h1234, 16'h4321, 16'h0000, 16'h0000);
    queue_word(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_word(OP_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000);
    queue_word(OP_DIV, 16'h7fff, 16'h8000, 16'h0000, 16'hffff);
    queue_word(OP_DIV, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000);
    queue_word(OP_DIV, 16'h0001, 16'h0000, 16'h0003, 16'h0000);
    queue_word(OP_DIV, 16'hffff, 16'h0000, 16'h0003, 16'h0000);
    queue_word(OP_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0001);
    queue_word(OP_DIV, 16'h0005, 16'hfffb, 16'h8000, 16'h0001);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      op = cna_op_e'($urandom_range(3));
      if (op == OP_DIV && $urandom_range(9) == 0)
        queue_word(op, pick_operand(), pick_operand(), '0, '0);
      else
        queue_word(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_words.size() == 0 && expected_results.size() == 0);
    // Let the pipeline drain so a stray extra word gets caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cna_pkg.sv
rtl/cna_if.sv
rtl/cna_div_pipe.sv
rtl/cna_front.sv
rtl/complex_number_alu.sv
tb/complex_number_alu_tb.sv
